/* src/fsp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package fsp_pkg;

  // Width of the saturating number accumulators.
  localparam int unsigned NumberBits = 16;
  // Width that holds acc * 10 + 9 without overflow.
  localparam int unsigned WideBits   = NumberBits + 4;

  typedef logic [NumberBits-1:0] num_t;
  typedef logic [2:0]            type_t;
  typedef logic [7:0]            char_t;
  typedef logic [3:0]            phase_t;

  localparam num_t NumMax = {NumberBits{1'b1}};

  // Descriptor letter codes as reported on type_code.
  localparam type_t TypeI = 3'd0;
  localparam type_t TypeF = 3'd1;
  localparam type_t TypeE = 3'd2;
  localparam type_t TypeD = 3'd3;
  localparam type_t TypeG = 3'd4;

  // Parser phases.
  localparam phase_t PhOpen   = 4'd0;
  localparam phase_t PhRepeat = 4'd1;
  localparam phase_t PhWFirst = 4'd2;
  localparam phase_t PhWMore  = 4'd3;
  localparam phase_t PhNFirst = 4'd4;
  localparam phase_t PhNMore  = 4'd5;
  localparam phase_t PhXFirst = 4'd6;
  localparam phase_t PhXMore  = 4'd7;
  localparam phase_t PhError  = 4'd8;

  // Character codes.
  localparam char_t ChNul   = 8'h00;
  localparam char_t ChTab   = 8'h09;
  localparam char_t ChSpace = 8'h20;
  localparam char_t ChOpen  = 8'h28;
  localparam char_t ChClose = 8'h29;
  localparam char_t ChDot   = 8'h2E;
  localparam char_t ChZero  = 8'h30;
  localparam char_t ChNine  = 8'h39;
  localparam char_t ChExpE  = 8'h45;

  typedef struct packed {
    logic  hit;
    type_t code;
  } letter_t;

  // One parsed descriptor as delivered on the output side.
  typedef struct packed {
    logic  ok;
    type_t type_code;
    num_t  repeat_count;
    num_t  field_width;
    num_t  first_number;
    num_t  exponent_digits;
  } res_t;

  function automatic logic is_digit(char_t c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  function automatic letter_t letter_code(char_t c);
    letter_t l;
    l.hit  = 1'b1;
    l.code = TypeI;
    unique case (c)
      8'h49, 8'h69: l.code = TypeI;
      8'h46, 8'h66: l.code = TypeF;
      8'h45, 8'h65: l.code = TypeE;
      8'h44, 8'h64: l.code = TypeD;
      8'h47, 8'h67: l.code = TypeG;
      default:      l.hit  = 1'b0;
    endcase
    return l;
  endfunction

  // acc * 10 + digit, clamped to the largest representable number.
  function automatic num_t add_digit(num_t acc, char_t c);
    logic [WideBits-1:0] wide;
    logic [WideBits-1:0] v;
    wide = {4'b0000, acc};
    v    = (wide << 3) + (wide << 1) + {{(WideBits-4){1'b0}}, c[3:0]};
    if (v > {4'b0000, NumMax}) begin
      return NumMax;
    end
    return v[NumberBits-1:0];
  endfunction

endpackage

`default_nettype wire

/* src/fsp_core.sv */
`timescale 1ns / 1ps
`default_nettype none

module fsp_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          beat_i,
  input  wire fsp_pkg::char_t char_i,
  input  wire logic          last_i,
  output logic               emit_o,
  output fsp_pkg::res_t      res_o
);
  import fsp_pkg::*;

  phase_t phase_q, phase_d;
  type_t  type_q, type_d;
  num_t   rep_q, rep_d;
  num_t   wid_q, wid_d;
  num_t   num_q, num_d;
  num_t   exp_q, exp_d;
  logic   given_q, given_d;

  logic    emit, ok, bad, digit;
  letter_t let_c;

  assign digit = is_digit(char_i);
  assign let_c = letter_code(char_i);

  always_comb begin
    phase_d = phase_q;
    type_d  = type_q;
    rep_d   = rep_q;
    wid_d   = wid_q;
    num_d   = num_q;
    exp_d   = exp_q;
    given_d = given_q;
    emit    = 1'b0;
    ok      = 1'b0;
    bad     = 1'b0;
    if (beat_i) begin
      if (!given_q) begin
        if (char_i == ChNul) begin
          emit = 1'b1;
        end else if (phase_q == PhError) begin
          emit = (char_i == ChClose);
        end else begin
          unique case (phase_q)
            PhOpen: begin
              if (char_i == ChOpen) begin
                phase_d = PhRepeat;
              end else if (char_i != ChSpace && char_i != ChTab) begin
                bad = 1'b1;
              end
            end
            PhRepeat: begin
              if (digit) begin
                rep_d = add_digit(rep_q, char_i);
              end else if (let_c.hit) begin
                type_d  = let_c.code;
                phase_d = PhWFirst;
              end else begin
                bad = 1'b1;
              end
            end
            PhWFirst, PhWMore: begin
              priority if (digit) begin
                wid_d   = add_digit(wid_q, char_i);
                phase_d = PhWMore;
              end else if (phase_q == PhWFirst) begin
                bad = 1'b1;
              end else if (char_i == ChDot) begin
                phase_d = PhNFirst;
              end else if (char_i == ChClose && type_q == TypeI) begin
                ok = 1'b1;
              end else begin
                bad = 1'b1;
              end
            end
            PhNFirst, PhNMore: begin
              priority if (digit) begin
                num_d   = add_digit(num_q, char_i);
                phase_d = PhNMore;
              end else if (phase_q == PhNFirst) begin
                bad = 1'b1;
              end else if (char_i == ChClose) begin
                ok = 1'b1;
              end else if (char_i == ChExpE && type_q >= TypeE) begin
                phase_d = PhXFirst;
              end else begin
                bad = 1'b1;
              end
            end
            PhXFirst, PhXMore: begin
              priority if (digit) begin
                exp_d   = add_digit(exp_q, char_i);
                phase_d = PhXMore;
              end else if (phase_q == PhXMore && char_i == ChClose) begin
                ok = 1'b1;
              end else begin
                bad = 1'b1;
              end
            end
            default: bad = 1'b1;
          endcase
          if (ok) begin
            emit = 1'b1;
          end
          if (bad) begin
            phase_d = PhError;
            emit    = (char_i == ChClose);
          end
        end
        if (last_i) begin
          emit = 1'b1;
        end
        if (emit) begin
          given_d = 1'b1;
        end
      end
      // The final character of a string returns the parser to its idle state.
      if (last_i) begin
        phase_d = PhOpen;
        type_d  = TypeI;
        rep_d   = '0;
        wid_d   = '0;
        num_d   = '0;
        exp_d   = '0;
        given_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhOpen;
      type_q  <= TypeI;
      rep_q   <= '0;
      wid_q   <= '0;
      num_q   <= '0;
      exp_q   <= '0;
      given_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      type_q  <= type_d;
      rep_q   <= rep_d;
      wid_q   <= wid_d;
      num_q   <= num_d;
      exp_q   <= exp_d;
      given_q <= given_d;
    end
  end

  // Fields come from the state before this character; an accepting ')' never
  // changes the accumulators.
  assign emit_o                = emit;
  assign res_o.ok              = ok;
  assign res_o.type_code       = ok ? type_q : TypeI;
  assign res_o.repeat_count    = ok ? rep_q : '0;
  assign res_o.field_width     = ok ? wid_q : '0;
  assign res_o.first_number    = ok ? num_q : '0;
  assign res_o.exponent_digits = ok ? exp_q : '0;

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat_i && given_q |-> !emit_o)
    else $error("second result for one string");

  a_last_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat_i && last_i |=> phase_q == PhOpen && !given_q)
    else $error("parser not idle after final character");

  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat_i && last_i && !given_q |-> emit_o)
    else $error("string ended without a result");

endmodule

`default_nettype wire

/* src/fortran_format_spec_parser.sv */
`timescale 1ns / 1ps
`default_nettype none

// Streaming parser for one Fortran edit descriptor such as (10E15.8E2), fed one
// character per input beat. Each beat is captured in an input register and
// evaluated against the parser state once the output register can take a
// result; any result lands in that output register. The block sustains one
// character per cycle while the output is not stalled by out_ready_i. The rate
// is set by the parser state loop, which updates the phase and one saturating
// multiply-by-ten accumulator per character. Exactly one result beat is
// produced per string, at the first ')' or at the end of the string (a zero
// character code or a beat with last_char_i set); when spec_ok_o is low every
// other result field is zero. Numbers saturate at 65535. The beat with
// last_char_i set returns the parser to its idle state for the next string.
module fortran_format_spec_parser (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire fsp_pkg::char_t char_code_i,
  input  wire logic           last_char_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic                spec_ok_o,
  output fsp_pkg::type_t      type_code_o,
  output fsp_pkg::num_t       repeat_count_o,
  output fsp_pkg::num_t       field_width_o,
  output fsp_pkg::num_t       first_number_o,
  output fsp_pkg::num_t       exponent_digits_o
);
  import fsp_pkg::*;

  // Input register.
  logic  in_valid_q;
  char_t in_char_q;
  logic  in_last_q;

  // Output register.
  logic  out_valid_q;
  res_t  res_q;

  logic  advance;
  logic  emit;
  res_t  res_c;

  // A captured character is evaluated whenever the output register can take
  // whatever it might produce: it is empty now or is being drained this cycle.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_char_q <= char_code_i;
      in_last_q <= last_char_i;
    end
  end

  fsp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .beat_i (advance),
    .char_i (in_char_q),
    .last_i (in_last_q),
    .emit_o (emit),
    .res_o  (res_c)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      res_q <= res_c;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign spec_ok_o         = res_q.ok;
  assign type_code_o       = res_q.type_code;
  assign repeat_count_o    = res_q.repeat_count;
  assign field_width_o     = res_q.field_width;
  assign first_number_o    = res_q.first_number;
  assign exponent_digits_o = res_q.exponent_digits;

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !spec_ok_o |-> type_code_o == TypeI && repeat_count_o == '0 &&
      field_width_o == '0 && first_number_o == '0 && exponent_digits_o == '0)
    else $error("malformed result carries nonzero fields");

  a_type_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && spec_ok_o |-> type_code_o <= TypeG)
    else $error("type code out of range");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !advance)
    else $error("pending result overwritten");

endmodule

`default_nettype wire
